[rtl/core/blg_pkg.sv]
// Shared widths, constants and register codes of the battery level gauge.
package blg_pkg;

    localparam int ADC_W       = 12;
    localparam int MV_W        = 13;
    localparam int PCT_W       = 7;
    localparam int GAIN_W      = 16;
    localparam int OFFSET_W    = 10;
    localparam int WEIGHT_W    = 11;
    localparam int LEVEL_W     = 23;
    localparam int LEVEL_FRAC  = 16;
    localparam int WEIGHT_FRAC = 10;

    // (mv - empty) * 100 stays below 2^20
    localparam int NUM_W = MV_W + PCT_W;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = LEVEL_W;
    localparam int MUL_B_W = GAIN_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Moving-average accumulator
    localparam int ACC_W = LEVEL_W + WEIGHT_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int SAMPLES_PER_READING_DEF = 10;
    localparam int ADC_BITS_DEF            = 12;

    localparam logic [MV_W-1:0]     MV_MAX     = 13'd8191;
    localparam logic [PCT_W-1:0]    PCT_FULL   = 7'd100;
    localparam logic [PCT_W-1:0]    PCT_EMPTY  = 7'd0;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 11'd1024;

    localparam logic [GAIN_W-1:0]   CAL_GAIN_RST      = 16'd51000;
    localparam logic [OFFSET_W-1:0] CAL_OFFSET_RST    = 10'd0;
    localparam logic [MV_W-1:0]     FULL_MV_RST       = 13'd4150;
    localparam logic [MV_W-1:0]     EMPTY_MV_RST      = 13'd3300;
    localparam logic [MV_W-1:0]     CHARGE_MV_RST     = 13'd4180;
    localparam logic [WEIGHT_W-1:0] SMOOTH_WEIGHT_RST = 11'd51;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_GAIN      = 3'd0,
        REG_CAL_OFFSET    = 3'd1,
        REG_FULL_MV       = 3'd2,
        REG_EMPTY_MV      = 3'd3,
        REG_CHARGE_MV     = 3'd4,
        REG_SMOOTH_WEIGHT = 3'd5
    } cfg_reg_t;

endpackage

[rtl/core/blg_ifs.sv]
// Handshake channel interfaces of the battery level gauge.
interface blg_sample_if
    import blg_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface blg_level_if
    import blg_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PCT_W-1:0] battery_percent;
    logic             charging;
    logic [MV_W-1:0]  battery_mv;

    modport source (output valid, output battery_percent, output charging,
                    output battery_mv, input ready);
    modport sink   (input valid, input battery_percent, input charging,
                    input battery_mv, output ready);
endinterface

interface blg_cfg_if
    import blg_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/battery_level_gauge.sv]
// Battery level gauge: batch average, calibration, percent mapping and smoothing.
//
// Samples enter one per cycle on the samples channel while the block is idle; every
// SAMPLES_PER_READING-th sample closes a batch and yields one transaction on the
// levels channel with the batch voltage (mV, saturated at 8191), the smoothed percent
// and the charging flag. A sample that does not close a batch leaves the block idle.
// After the closing sample is taken, samples.ready stays low through the average and
// calibration multiplies, calibration, level test and, for a voltage strictly inside
// the empty..full span, span setup and divider, then smoothing and output; the first
// batch after reset skips the blend states. Output waits while the previous result
// is still unread. The batch average comes from one multiply by the reciprocal of the
// batch length, and the percent inside the span from one bit-serial restoring divider
// (DIV_W steps). One registered multiplier serves the average, calibration, percent
// scaling and both smoothing terms. A finished result waits in an output register,
// so sampling goes on while it is pending. Register writes on cfg are accepted while
// the block is idle and apply to the batch that closes next.
module battery_level_gauge
    import blg_pkg::*;
#(
    parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF,
    parameter int ADC_BITS            = ADC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    blg_sample_if.sink   samples,
    blg_level_if.source  levels,
    blg_cfg_if.sink      cfg
);

    localparam int SAMPLE_W = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
    localparam int SUM_W    = SAMPLE_W + $clog2(SAMPLES_PER_READING);
    localparam int CNT_W    = $clog2(SAMPLES_PER_READING + 1);
    localparam int DIV_W    = (SUM_W > NUM_W) ? SUM_W : NUM_W;
    localparam int DCNT_W   = $clog2(DIV_W + 1);

    // Rounded-up reciprocal of the batch length; exact for every SUM_W-bit sum
    localparam int AVG_SHIFT = SUM_W + $clog2(SAMPLES_PER_READING);
    localparam int AVG_RECIP = ((1 << AVG_SHIFT) + SAMPLES_PER_READING - 1)
                             / SAMPLES_PER_READING;

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_MUL_AVG = 11'b000_0000_0010,
        ST_MUL_MV  = 11'b000_0000_0100,
        ST_CAL     = 11'b000_0000_1000,
        ST_LVL     = 11'b000_0001_0000,
        ST_SPAN    = 11'b000_0010_0000,
        ST_DIV_LVL = 11'b000_0100_0000,
        ST_SM_A    = 11'b000_1000_0000,
        ST_SM_B    = 11'b001_0000_0000,
        ST_SM_C    = 11'b010_0000_0000,
        ST_OUT     = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [GAIN_W-1:0]   cal_gain_reg,      cal_gain_next;
    logic [OFFSET_W-1:0] cal_offset_reg,    cal_offset_next;
    logic [MV_W-1:0]     full_mv_reg,       full_mv_next;
    logic [MV_W-1:0]     empty_mv_reg,      empty_mv_next;
    logic [MV_W-1:0]     charge_mv_reg,     charge_mv_next;
    logic [WEIGHT_W-1:0] smooth_weight_reg, smooth_weight_next;

    logic [CNT_W-1:0]    batch_count_reg,   batch_count_next;
    logic [SUM_W-1:0]    sample_sum_reg,    sample_sum_next;
    logic [LEVEL_W-1:0]  smoothed_reg,      smoothed_next;
    logic                level_valid_reg,   level_valid_next;

    logic [MV_W-1:0]     mv_reg,            mv_next;
    logic [PCT_W-1:0]    lvl_reg,           lvl_next;
    logic [ACC_W-2:0]    acc_reg,           acc_next;
    logic [PROD_W-1:0]   prod_reg,          prod_next;

    logic [DIV_W-1:0]    quo_reg,           quo_next;
    logic [MV_W-1:0]     rem_reg,           rem_next;
    logic [MV_W-1:0]     divisor_reg,       divisor_next;
    logic [DCNT_W-1:0]   div_cnt_reg,       div_cnt_next;

    logic                out_valid_reg,     out_valid_next;
    logic [PCT_W-1:0]    out_pct_reg,       out_pct_next;
    logic                out_chg_reg,       out_chg_next;
    logic [MV_W-1:0]     out_mv_reg,        out_mv_next;

    logic [SAMPLE_W-1:0] sample;
    logic [SUM_W-1:0]    sum_total;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MV_W:0]       trial;
    logic [MV_W+1:0]     diff;
    logic                borrow;
    logic [DIV_W-1:0]    step_quo;
    logic [MV_W-1:0]     step_rem;
    logic [MV_W-1:0]     mv_half;
    logic [MV_W:0]       mv_dbl;
    logic [WEIGHT_W-1:0] w_eff;
    logic [ACC_W-1:0]    acc_sum;
    logic                out_free;

    assign sample    = samples.adc_sample[SAMPLE_W-1:0];
    assign sum_total = sample_sum_reg + SUM_W'(sample);

    assign samples.ready = (state_reg == ST_IDLE);
    assign cfg.ready     = (state_reg == ST_IDLE);

    assign levels.valid           = out_valid_reg;
    assign levels.battery_percent = out_pct_reg;
    assign levels.charging        = out_chg_reg;
    assign levels.battery_mv      = out_mv_reg;

    assign out_free = !out_valid_reg || levels.ready;

    // One restoring division step
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign diff     = {1'b0, trial} - {2'b00, divisor_reg};
    assign borrow   = diff[MV_W+1];
    assign step_rem = borrow ? trial[MV_W-1:0] : diff[MV_W-1:0];
    assign step_quo = {quo_reg[DIV_W-2:0], !borrow};

    assign mv_half = MV_W'(prod_reg[SAMPLE_W+LEVEL_FRAC-1:LEVEL_FRAC]) + MV_W'(cal_offset_reg);
    assign mv_dbl  = {mv_half, 1'b0};

    assign w_eff   = (smooth_weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : smooth_weight_reg;
    assign acc_sum = {1'b0, acc_reg}
                   + ACC_W'({prod_reg[PCT_W+WEIGHT_W-1:0], {LEVEL_FRAC{1'b0}}});

    // Operand select of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_AVG:
            begin
                mul_a = MUL_A_W'(AVG_RECIP);
                mul_b = MUL_B_W'(quo_reg[SUM_W-1:0]);
            end
            ST_MUL_MV:
            begin
                mul_a = MUL_A_W'(prod_reg[AVG_SHIFT+SAMPLE_W-1:AVG_SHIFT]);
                mul_b = cal_gain_reg;
            end
            ST_LVL:
            begin
                mul_a = MUL_A_W'(mv_reg - empty_mv_reg);
                mul_b = MUL_B_W'(PCT_FULL);
            end
            ST_SM_A:
            begin
                mul_a = smoothed_reg;
                mul_b = MUL_B_W'(WEIGHT_ONE - w_eff);
            end
            ST_SM_B:
            begin
                mul_a = MUL_A_W'(lvl_reg);
                mul_b = MUL_B_W'(w_eff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        state_next         = state_reg;
        cal_gain_next      = cal_gain_reg;
        cal_offset_next    = cal_offset_reg;
        full_mv_next       = full_mv_reg;
        empty_mv_next      = empty_mv_reg;
        charge_mv_next     = charge_mv_reg;
        smooth_weight_next = smooth_weight_reg;
        batch_count_next   = batch_count_reg;
        sample_sum_next    = sample_sum_reg;
        smoothed_next      = smoothed_reg;
        level_valid_next   = level_valid_reg;
        mv_next            = mv_reg;
        lvl_next           = lvl_reg;
        acc_next           = acc_reg;
        quo_next           = quo_reg;
        rem_next           = rem_reg;
        divisor_next       = divisor_reg;
        div_cnt_next       = div_cnt_reg;
        out_valid_next     = out_valid_reg;
        out_pct_next       = out_pct_reg;
        out_chg_next       = out_chg_reg;
        out_mv_next        = out_mv_reg;

        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_CAL_GAIN:      cal_gain_next      = cfg.data[GAIN_W-1:0];
                REG_CAL_OFFSET:    cal_offset_next    = cfg.data[OFFSET_W-1:0];
                REG_FULL_MV:       full_mv_next       = cfg.data[MV_W-1:0];
                REG_EMPTY_MV:      empty_mv_next      = cfg.data[MV_W-1:0];
                REG_CHARGE_MV:     charge_mv_next     = cfg.data[MV_W-1:0];
                REG_SMOOTH_WEIGHT: smooth_weight_next = cfg.data[WEIGHT_W-1:0];
                default:           ;
            endcase
        end

        if (out_valid_reg && levels.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    if (batch_count_reg == CNT_W'(SAMPLES_PER_READING - 1))
                    begin
                        // Close the batch and hold its sum for the average
                        batch_count_next = '0;
                        sample_sum_next  = '0;
                        quo_next         = DIV_W'(sum_total);
                        state_next       = ST_MUL_AVG;
                    end
                    else
                    begin
                        batch_count_next = batch_count_reg + CNT_W'(1);
                        sample_sum_next  = sum_total;
                    end
                end
            end
            ST_MUL_AVG:
            begin
                state_next = ST_MUL_MV;
            end
            ST_MUL_MV:
            begin
                state_next = ST_CAL;
            end
            ST_CAL:
            begin
                mv_next    = mv_dbl[MV_W] ? MV_MAX : mv_dbl[MV_W-1:0];
                state_next = ST_LVL;
            end
            ST_LVL:
            begin
                // Full test first, so a reversed span still clamps cleanly
                if (mv_reg >= full_mv_reg)
                begin
                    lvl_next   = PCT_FULL;
                    state_next = ST_SM_A;
                end
                else if (mv_reg <= empty_mv_reg)
                begin
                    lvl_next   = PCT_EMPTY;
                    state_next = ST_SM_A;
                end
                else
                begin
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                quo_next     = DIV_W'(prod_reg[NUM_W-1:0]);
                rem_next     = '0;
                divisor_next = full_mv_reg - empty_mv_reg;
                div_cnt_next = DCNT_W'(DIV_W);
                state_next   = ST_DIV_LVL;
            end
            ST_DIV_LVL:
            begin
                quo_next     = step_quo;
                rem_next     = step_rem;
                div_cnt_next = div_cnt_reg - DCNT_W'(1);
                if (div_cnt_reg == DCNT_W'(1))
                begin
                    lvl_next   = step_quo[PCT_W-1:0];
                    state_next = ST_SM_A;
                end
            end
            ST_SM_A:
            begin
                if (!level_valid_reg)
                begin
                    // Take the first batch as is
                    smoothed_next    = {lvl_reg, {LEVEL_FRAC{1'b0}}};
                    level_valid_next = 1'b1;
                    state_next       = ST_OUT;
                end
                else
                begin
                    state_next = ST_SM_B;
                end
            end
            ST_SM_B:
            begin
                acc_next   = prod_reg[ACC_W-2:0];
                state_next = ST_SM_C;
            end
            ST_SM_C:
            begin
                smoothed_next = acc_sum[LEVEL_W+WEIGHT_FRAC-1:WEIGHT_FRAC];
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pct_next   = smoothed_reg[LEVEL_W-1:LEVEL_FRAC];
                    out_chg_next   = (mv_reg >= charge_mv_reg);
                    out_mv_next    = mv_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cal_gain_reg      <= CAL_GAIN_RST;
            cal_offset_reg    <= CAL_OFFSET_RST;
            full_mv_reg       <= FULL_MV_RST;
            empty_mv_reg      <= EMPTY_MV_RST;
            charge_mv_reg     <= CHARGE_MV_RST;
            smooth_weight_reg <= SMOOTH_WEIGHT_RST;
            batch_count_reg   <= '0;
            sample_sum_reg    <= '0;
            smoothed_reg      <= '0;
            level_valid_reg   <= 1'b0;
            div_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            cal_gain_reg      <= cal_gain_next;
            cal_offset_reg    <= cal_offset_next;
            full_mv_reg       <= full_mv_next;
            empty_mv_reg      <= empty_mv_next;
            charge_mv_reg     <= charge_mv_next;
            smooth_weight_reg <= smooth_weight_next;
            batch_count_reg   <= batch_count_next;
            sample_sum_reg    <= sample_sum_next;
            smoothed_reg      <= smoothed_next;
            level_valid_reg   <= level_valid_next;
            div_cnt_reg       <= div_cnt_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_reg      <= mv_next;
        lvl_reg     <= lvl_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        out_pct_reg <= out_pct_next;
        out_chg_reg <= out_chg_next;
        out_mv_reg  <= out_mv_next;
    end

endmodule
